FILE: rtl/skrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_pkg
// types, codes and sizes shared by the sorted key record table
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
    logic [31:0] marks;
  } rec_t;

  // broadcast command from the controller to every cell; the compare key
  // travels on its own wire so the match tree does not feed back into it
  typedef struct packed {
    cell_op_t    op;
    logic        found;
    rec_t        rec;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/skrt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_req_if
// request channel: opcode, key and record payload with valid/ready
// ----------------------------------------------------------------------------
interface skrt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] key_id;
  logic [63:0] name_low;
  logic [63:0] name_mid;
  logic [31:0] name_high;
  logic [31:0] marks_bits;

  modport source (
    output valid, opcode, key_id, name_low, name_mid, name_high, marks_bits,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_id, name_low, name_mid, name_high, marks_bits,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/skrt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_rsp_if
// result channel: status, listed entry and last marker with valid/ready
// ----------------------------------------------------------------------------
interface skrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] entry_key;
  logic [63:0] entry_name_low;
  logic [63:0] entry_name_mid;
  logic [31:0] entry_name_high;
  logic [31:0] entry_marks;
  logic        last;

  modport source (
    output valid, status, entry_key, entry_name_low, entry_name_mid,
           entry_name_high, entry_marks, last,
    input  ready
  );
  modport sink (
    input  valid, status, entry_key, entry_name_low, entry_name_mid,
           entry_name_high, entry_marks, last,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/skrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_cell
// one slot of the sorted chain: holds a record, compares it against the
// broadcast key and takes the new record or a neighbor's record
// ----------------------------------------------------------------------------
module skrt_cell
  import skrt_pkg::*;
(
  input  wire logic        clk,
  input  wire cell_cmd_t   cmd,
  input  wire logic [31:0] key,          // broadcast compare key
  input  wire logic        head,         // first cell: equal key counts as ahead
  input  wire logic        occ,          // slot holds a live entry
  input  wire logic        tail,         // last live entry
  input  wire logic        left_before,
  input  wire logic        left_occ,
  input  wire rec_t        left_rec,
  input  wire rec_t        right_rec,
  input  wire rec_t        head_rec,
  output logic             ahead,        // new key goes after this slot
  output logic             match,
  output rec_t             rec
);

  logic key_lt;
  logic key_eq;

  assign key_lt = $signed(rec.key) < $signed(key);
  assign key_eq = rec.key == key;

  assign ahead = occ && (key_lt || (head && key_eq));
  assign match = occ && key_eq;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INS: begin
        if (left_before && !ahead) begin
          rec <= cmd.rec;
        end else if (!left_before && left_occ) begin
          rec <= left_rec;
        end
      end
      CELL_DEL: begin
        // every slot from the first match on moves one place toward the head
        if (cmd.found && occ && !key_lt) begin
          rec <= right_rec;
        end
      end
      CELL_ROT: begin
        rec <= tail ? head_rec : right_rec;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/sorted_key_record_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_record_table
// bounded table of records kept in signed key order in a chain of cells
// ----------------------------------------------------------------------------
// usage
//   req  : one beat per command (insert, delete by key, list all entries)
//   rsp  : result beats; last marks the final beat of each command
//   insert and delete: every cell compares its key with the broadcast key
//   at once and shifts toward the tail or the head; the single status beat
//   appears in the output register the cycle after acceptance
//   list gives one beat per live entry: the chain rotates one place a cycle
//   while the output register is free and cell 0 feeds the output register,
//   so after n beats the table is back in its original order; an empty
//   table gives one list-empty beat
//   an unused opcode is accepted and gives no beat
//   req.ready drops during a list and while the output register is full and
//   not taken; a stalled receiver freezes the rotation, nothing is lost
//   reset (synchronous, active high) empties the table through the fill
//   count; record storage itself is not cleared
// ----------------------------------------------------------------------------
module sorted_key_record_table
  import skrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  skrt_req_if.sink  req,
  skrt_rsp_if.source rsp
);

  // fill count and list walk
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   lidx;
  logic [CNT_W-1:0]   lidx_next;

  // output register
  logic               out_valid;
  logic               out_valid_next;
  status_t            out_status;
  status_t            out_status_next;
  rec_t               out_rec;
  rec_t               out_rec_next;
  logic               out_last;
  logic               out_last_next;

  // chain
  cell_cmd_t          cmd;
  rec_t               recs   [DEPTH];
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   ahead;
  logic [DEPTH-1:0]   match;
  logic               found;
  logic               full;
  logic               out_free;
  logic               accept;
  logic               list_last;

  assign full      = count == CNT_W'(DEPTH);
  assign found     = |match;
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign list_last = lidx == count - CNT_W'(1);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign occ[gi] = count > CNT_W'(gi);

      logic l_before;
      logic l_occ;
      logic c_tail;
      rec_t l_rec;
      rec_t r_rec;

      if (gi == 0) begin : g_first
        assign l_before = 1'b1;
        assign l_occ    = 1'b1;
        assign l_rec    = recs[0];
      end else begin : g_rest
        assign l_before = ahead[gi-1];
        assign l_occ    = occ[gi-1];
        assign l_rec    = recs[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_end
        assign c_tail = occ[gi];
        assign r_rec  = recs[0];
      end else begin : g_mid
        assign c_tail = occ[gi] && !occ[gi+1];
        assign r_rec  = recs[gi+1];
      end

      skrt_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .key         (req.key_id),
        .head        (gi == 0),
        .occ         (occ[gi]),
        .tail        (c_tail),
        .left_before (l_before),
        .left_occ    (l_occ),
        .left_rec    (l_rec),
        .right_rec   (r_rec),
        .head_rec    (recs[0]),
        .ahead       (ahead[gi]),
        .match       (match[gi]),
        .rec         (recs[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      lidx      <= lidx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_rec    <= out_rec_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    lidx_next       = lidx;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_rec_next    = out_rec;
    out_last_next   = out_last;

    cmd.op          = CELL_HOLD;
    cmd.found       = found;
    cmd.rec.key       = req.key_id;
    cmd.rec.name_low  = req.name_low;
    cmd.rec.name_mid  = req.name_mid;
    cmd.rec.name_high = req.name_high;
    cmd.rec.marks     = req.marks_bits;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_INSERT: begin
              out_valid_next  = 1'b1;
              out_rec_next    = '0;
              out_last_next   = 1'b1;
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                cmd.op          = CELL_INS;
                count_next      = count + CNT_W'(1);
                out_status_next = ST_OK;
              end
            end
            OP_DELETE: begin
              out_valid_next  = 1'b1;
              out_rec_next    = '0;
              out_last_next   = 1'b1;
              if (found) begin
                cmd.op          = CELL_DEL;
                count_next      = count - CNT_W'(1);
                out_status_next = ST_OK;
              end else begin
                out_status_next = ST_NOT_FOUND;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
                out_rec_next    = '0;
                out_last_next   = 1'b1;
              end else begin
                state_next = S_LIST;
                lidx_next  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        // one entry per beat from the head, rotating the chain behind it
        if (out_free) begin
          cmd.op          = CELL_ROT;
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_rec_next    = recs[0];
          out_last_next   = list_last;
          lidx_next       = lidx + CNT_W'(1);
          if (list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.entry_key       = out_rec.key;
  assign rsp.entry_name_low  = out_rec.name_low;
  assign rsp.entry_name_mid  = out_rec.name_mid;
  assign rsp.entry_name_high = out_rec.name_high;
  assign rsp.entry_marks     = out_rec.marks;
  assign rsp.last            = out_last;

  // an insert that fits grows the table by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == OP_INSERT && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

  // a delete shrinks the table by at most one
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && req.opcode == OP_DELETE |=>
      count == $past(count) || count == $past(count) - CNT_W'(1))
    else $error("delete changed the count by more than one");

  // no new command is taken while a list is being walked
  a_list_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_LIST |-> !req.ready)
    else $error("request taken during list");

  // head pair stays in key order outside a list walk
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && count >= CNT_W'(2) |->
      $signed(recs[0].key) <= $signed(recs[1].key))
    else $error("head entries out of key order");

  // the fill count stays within the table size after each accepted command
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    accept |=> count <= CNT_W'(DEPTH))
    else $error("fill count beyond table size");

endmodule
`default_nettype wire
